[hw/rtl/blist_pkg.sv]
package blist_pkg;

  // Operation codes of an input word
  localparam logic [1:0] OpAppend = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;
  localparam logic [1:0] OpDump   = 2'd2;

  // Result kinds
  localparam logic [1:0] KindAck   = 2'd0;
  localparam logic [1:0] KindElem  = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  // Result status codes
  localparam logic [1:0] StatDone  = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatRange = 2'd2;

  // Most results one dump may give
  localparam int unsigned MaxResults = 16;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [3:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] element;
    logic [3:0]         slot;
    logic [1:0]         status;
    logic [4:0]         entries_held;
    logic               final_res;
  } out_word_t;

endpackage

[hw/rtl/blist_mem.sv]
module blist_mem #(
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic signed [31:0]       wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic signed [31:0]       rdata_o
);

  logic signed [31:0] mem_q [Depth];
  logic signed [31:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/blist_seq.sv]
module blist_seq #(
  parameter int unsigned Capacity = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  blist_pkg::in_word_t           in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output blist_pkg::out_word_t          out_word_o,
  output logic                          mem_we_o,
  output logic [$clog2(Capacity)-1:0]   mem_waddr_o,
  output logic signed [31:0]            mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(Capacity)-1:0]   mem_raddr_o,
  input  logic signed [31:0]            mem_rdata_i
);
  import blist_pkg::*;

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned XW = (CW > 4) ? CW : 4;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDel  = 2'd1;
  localparam logic [1:0] StAck  = 2'd2;
  localparam logic [1:0] StDump = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] src_q, src_d;
  logic [CW-1:0] dst_q, dst_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;
  out_word_t     out_word_q;
  out_word_t     out_d;
  logic          out_load;
  logic          out_free;
  logic          in_acc;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          dump_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_x      = XW'(in_word_i.position);
  assign cnt_x      = XW'(count_q);

  // Last listed word: end of the list or the result limit
  assign dump_last = (src_q == count_q - CW'(1)) ||
                     (8'(src_q) == 8'(MaxResults - 1));

  // Sequencer: dispatch words, move entries, list entries
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    src_d       = src_q;
    dst_d       = dst_q;
    pend_d      = pend_q;
    out_load    = 1'b0;
    out_d       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AW-1:0];
    mem_wdata_o = in_word_i.value;
    mem_re_o    = 1'b0;
    mem_raddr_o = src_q[AW-1:0];

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          out_d.kind      = KindAck;
          out_d.final_res = 1'b1;
          out_d.status    = StatDone;
          out_d.entries_held = 5'(count_q);
          case (in_word_i.operation)
            OpAppend: begin
              out_load = 1'b1;
              if (count_q < CW'(Capacity)) begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
                out_d.entries_held = 5'(count_q + CW'(1));
              end else begin
                out_d.status = StatFull;
              end
            end
            OpDelete: begin
              if (pos_x < cnt_x) begin
                dst_d   = CW'(pos_x);
                src_d   = CW'(pos_x) + CW'(1);
                pend_d  = 1'b0;
                state_d = StDel;
              end else begin
                out_load     = 1'b1;
                out_d.status = StatRange;
              end
            end
            OpDump: begin
              if (count_q == '0) begin
                out_load   = 1'b1;
                out_d.kind = KindEmpty;
              end else begin
                src_d   = '0;
                pend_d  = 1'b0;
                state_d = StDump;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      StDel: begin
        // Write back the word read last cycle one slot lower
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = dst_q[AW-1:0];
          mem_wdata_o = mem_rdata_i;
          dst_d       = dst_q + CW'(1);
        end
        // Fetch the next word to move
        if (src_q < count_q) begin
          mem_re_o = 1'b1;
          src_d    = src_q + CW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CW'(1);
            state_d = StAck;
          end
        end
      end

      StAck: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_d.kind         = KindAck;
          out_d.status       = StatDone;
          out_d.entries_held = 5'(count_q);
          out_d.final_res    = 1'b1;
          state_d            = StIdle;
        end
      end

      StDump: begin
        if (!pend_q) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
        end else if (out_free) begin
          out_load           = 1'b1;
          out_d.kind         = KindElem;
          out_d.element      = mem_rdata_i;
          out_d.slot         = 4'(src_q);
          out_d.status       = StatDone;
          out_d.entries_held = 5'(count_q);
          out_d.final_res    = dump_last;
          if (dump_last) begin
            pend_d  = 1'b0;
            state_d = StIdle;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'(src_q + CW'(1));
            src_d       = src_q + CW'(1);
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output register: load a new word or drop the taken one
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
    if (out_load) begin
      out_word_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Capacity))
    else $error("entry count above capacity");

  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (state_q == StIdle) && out_free)
    else $error("word accepted while busy");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !out_load)
    else $error("stalled result overwritten");

  a_move_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDel) && mem_we_o |-> pend_q && (dst_q < count_q))
    else $error("move writes without fetched word");

  a_append_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.operation == OpAppend) && (count_q < CW'(Capacity))
    |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not grow the list");

endmodule

[hw/rtl/bounded_ordered_list.sv]
// Bounded ordered list of up to CAPACITY signed 32-bit values, kept in one
// memory with one registered read port and one write port. One input word is
// taken at a time. Append, a delete at or beyond the count, an unused code and
// a dump of an empty list each give one result straight from the idle state. A
// delete at position p moves each later entry down one slot through the
// memory, one read and one write a cycle, and ends with one acknowledgement.
// A dump of n entries (at most 16) first reads the first entry and then gives
// one result a cycle while the receiver does not stall. A full list drops an
// append and flags it. A delete at or beyond the count is ignored and flagged.
// Results wait in an output register while the receiver stalls. No clearing
// pass is needed after reset.
module bounded_ordered_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  blist_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output blist_pkg::out_word_t out_word_o
);
  import blist_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  // Entry storage
  blist_mem #(
    .Depth(CAPACITY)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Control and result register
  blist_seq #(
    .Capacity(CAPACITY)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import blist_pkg::*;

  localparam int unsigned ListCap    = 16;
  localparam logic [1:0]  OpUnused   = 2'd3;
  localparam int          HoldCycles = 300;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  // stimulus side
  in_word_t  pending_q[$];
  int        gen_len   = 0;
  bit        growing   = 1'b1;
  int        idle_pct  = 0;
  int        stall_pct = 0;
  int        hold_asked = 0;
  int        hold_served = 0;
  int        hold_left = 0;
  bit        in_taken  = 1'b0;

  // predictor state and expected results
  logic signed [31:0] list_mem [ListCap];
  int unsigned        list_len = 0;
  out_word_t          expect_q[$];
  int                 errors   = 0;

  bounded_ordered_list #(
    .CAPACITY(ListCap)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Format one result word for a report line.
  function automatic string fmt_word(input out_word_t w);
    return $sformatf("kind=%0d elem=%0d slot=%0d status=%0d held=%0d last=%0b",
                     w.kind, w.element, w.slot, w.status, w.entries_held,
                     w.final_res);
  endfunction

  // Queue one result word with the current list length.
  task automatic push_result(input logic [1:0] kind, input logic signed [31:0] elem,
                             input logic [3:0] slot, input logic [1:0] status,
                             input logic last);
    out_word_t r;
    r.kind         = kind;
    r.element      = elem;
    r.slot         = slot;
    r.status       = status;
    r.entries_held = 5'(list_len);
    r.final_res    = last;
    expect_q.push_back(r);
  endtask

  // Apply one accepted word to the list and queue the results it causes.
  task automatic list_apply(input in_word_t w);
    logic [1:0]  status;
    int unsigned n;
    status = StatDone;
    case (w.operation)
      OpAppend: begin
        if (list_len >= ListCap) begin
          status = StatFull;
        end else begin
          list_mem[list_len] = w.value;
          list_len++;
        end
      end
      OpDelete: begin
        if (w.position < list_len) begin
          for (int i = w.position; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end else begin
          status = StatRange;
        end
      end
      OpDump: begin
        n = (list_len < MaxResults) ? list_len : MaxResults;
        if (n == 0) begin
          push_result(KindEmpty, '0, '0, StatDone, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++)
            push_result(KindElem, list_mem[i], 4'(i), StatDone, i + 1 == n);
        end
        return;
      end
      default: ;
    endcase
    push_result(KindAck, '0, '0, status, 1'b1);
  endtask

  // Check results first, then predict from the word taken at the same edge.
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expect_q.size() == 0) begin
          errors++;
          $display("%0t: mismatch expected none, got %s", $time, fmt_word(out_word_o));
        end else begin
          want = expect_q.pop_front();
          if (out_word_o.kind !== want.kind || out_word_o.element !== want.element ||
              out_word_o.slot !== want.slot || out_word_o.status !== want.status ||
              out_word_o.entries_held !== want.entries_held ||
              out_word_o.final_res !== want.final_res) begin
            errors++;
            $display("%0t: mismatch expected %s, got %s", $time,
                     fmt_word(want), fmt_word(out_word_o));
          end
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) list_apply(in_word_i);
    end
  end

  // Offer the next word once the current one is taken; hold it while stalled.
  always @(negedge clk_i) begin : driver
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_word_i  <= pending_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the output at random, or hold it off for a long stretch on request.
  always @(negedge clk_i) begin : receiver
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_served <= hold_served + 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 39))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Queue one word and track the list length it leaves behind.
  task automatic add_word(input logic [1:0] op, input logic signed [31:0] val,
                          input logic [3:0] pos);
    in_word_t w;
    w.operation = op;
    w.value     = val;
    w.position  = pos;
    pending_q.push_back(w);
    if (op == OpAppend && gen_len < ListCap) gen_len++;
    else if (op == OpDelete && pos < gen_len) gen_len--;
  endtask

  // Random words: swing the list between nearly empty and full.
  task automatic add_random(input int n);
    int         pick;
    logic [1:0] op;
    logic [3:0] pos;
    for (int i = 0; i < n; i++) begin
      if (gen_len <= 2) growing = 1'b1;
      else if (gen_len == ListCap && $urandom_range(0, 1) == 1) growing = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < (growing ? 60 : 20)) op = OpAppend;
      else if (pick < 80) op = OpDelete;
      else if (pick < 97) op = OpDump;
      else op = OpUnused;
      pos = 4'($urandom_range(0, 15));
      if (op == OpDelete && gen_len != 0 && $urandom_range(0, 4) != 0)
        pos = 4'($urandom_range(0, gen_len - 1));
      add_word(op, pick_value(), pos);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int n);
    idle_pct  = idle;
    stall_pct = stall;
    add_random(n);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty list, extremes, gap closing, unused code, full list
    add_word(OpDump, '0, 4'd0);
    add_word(OpDelete, '0, 4'd0);
    add_word(OpDelete, '1, 4'd15);
    add_word(OpAppend, 32'h8000_0000, 4'd0);
    add_word(OpAppend, 32'h7fff_ffff, 4'd15);
    add_word(OpAppend, '0, 4'd0);
    add_word(OpAppend, '1, 4'd0);
    add_word(OpDump, '0, 4'd0);
    add_word(OpDelete, '0, 4'd1);
    add_word(OpUnused, 32'h5a5a_a5a5, 4'd9);
    while (gen_len < ListCap) add_word(OpAppend, pick_value(), 4'($urandom_range(0, 15)));
    add_word(OpAppend, 32'h1234_5678, 4'd0);
    add_word(OpDump, '0, 4'd0);
    add_word(OpDelete, '0, 4'd15);
    add_word(OpDelete, '0, 4'd0);
    while (pending_q.size() != 0) @(posedge clk_i);

    run_phase(0, 0, 70);
    run_phase(67, 0, 70);
    run_phase(0, 67, 70);
    run_phase(19, 19, 60);
    // long receiver hold-off while words keep coming
    hold_asked++;
    run_phase(0, 0, 40);

    // drain
    while (in_valid_i) @(posedge clk_i);
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
